/* design/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg: shared types, constants and functions
// Widths, CORDIC tables and gain constants for the direction to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;

  // datapath and angle widths (one turn = 2^32)
  localparam int W  = 36;
  localparam int AW = 34;
  localparam int NW = 30;  // normalized input components

  localparam logic signed [AW-1:0] ANG_QUARTER = AW'(64'sd1 << 30);
  localparam logic signed [AW-1:0] ANG_HALF    = AW'(64'sd1 << 31);
  localparam logic signed [AW-1:0] ANG_TURN    = AW'(64'sd1 << 32);
  localparam logic signed [39:0]   ONE_Q30     = 40'sd1 << 30;

  // atan(2^-i) in binary angle units
  localparam logic signed [AW-1:0] ARC_TABLE [32] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
    34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608,
    34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41, 34'sd20,
    34'sd10, 34'sd5, 34'sd3, 34'sd1, 34'sd1, 34'sd0};

  // bit-pair integer square root, evaluated at elaboration
  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bitv;
    res  = '0;
    rem  = n;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // CORDIC gain in Q30
  function automatic logic [63:0] gain_q30();
    logic [63:0] k2;
    k2 = 64'd1 << 30;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      k2 = k2 + (k2 >> ((2 * (i % 32)) % 64));
    end
    return root64(k2 << 30);
  endfunction

  localparam logic [63:0] GAIN    = gain_q30();
  localparam logic [63:0] GAIN_INV = ((64'd1 << 60) + GAIN / 2) / GAIN;
  localparam logic signed [31:0] K_Q30    = 32'(GAIN);
  localparam logic signed [W-1:0] KINV_Q30 = W'(GAIN_INV);

  // output scaling
  localparam int OSH = 30 - FRAC_BITS;
  localparam logic signed [39:0] OUT_ROUND = (OSH > 0) ? (40'sd1 <<< (OSH - 1)) : 40'sd0;
  localparam logic signed [39:0] OUT_LIM   = 40'sd1 <<< FRAC_BITS;

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_ZERO,
    CLS_SAME,
    CLS_OPP
  } cls_e;

  typedef struct packed {
    logic signed [W-1:0]  a;
    logic signed [W-1:0]  b;
    logic signed [AW-1:0] ang;
  } cord_t;

  typedef struct packed {
    cls_e                 cls;
    logic signed [AW-1:0] aux;
  } side_t;

  // vectoring pre-turn: bring the vector into the right half plane
  function automatic cord_t vec_pre(input logic signed [W-1:0] a,
                                    input logic signed [W-1:0] b);
    cord_t r;
    r.a   = a;
    r.b   = b;
    r.ang = '0;
    if (a[W-1]) begin
      if (!b[W-1]) begin
        r.a   = b;
        r.b   = -a;
        r.ang = ANG_QUARTER;
      end else begin
        r.a   = -b;
        r.b   = a;
        r.ang = -ANG_QUARTER;
      end
    end
    return r;
  endfunction

  // rotation pre-turn: wrap, then fold into [-quarter, quarter]
  function automatic cord_t rot_pre(input logic signed [AW-1:0] ang_in);
    cord_t r;
    logic signed [AW-1:0] ang;
    ang = ang_in;
    if (ang > ANG_HALF) ang = ang - ANG_TURN;
    if (ang < -ANG_HALF) ang = ang + ANG_TURN;
    r.a = KINV_Q30;
    r.b = '0;
    if (ang > ANG_QUARTER) begin
      r.a = '0;
      r.b = KINV_Q30;
      ang = ang - ANG_QUARTER;
    end else if (ang < -ANG_QUARTER) begin
      r.a = '0;
      r.b = -KINV_Q30;
      ang = ang + ANG_QUARTER;
    end
    r.ang = ang;
    return r;
  endfunction

  // Q30 to output format: round half up, saturate, keep 16 bits
  function automatic logic [15:0] to_out(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = (v + OUT_ROUND) >>> OSH;
    if (t > OUT_LIM) t = OUT_LIM;
    if (t < -OUT_LIM) t = -OUT_LIM;
    return t[15:0];
  endfunction

  localparam logic [15:0] OUT_ONE = to_out(ONE_Q30);

endpackage

/* design/dtq_in_if.sv */
// ----------------------------------------------------------------------------
// dtq_in_if: direction request channel
// Valid/ready channel carrying one direction vector.
// ----------------------------------------------------------------------------
interface dtq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

/* design/dtq_out_if.sv */
// ----------------------------------------------------------------------------
// dtq_out_if: quaternion result channel
// Valid/ready channel carrying one Q1.14 quaternion and the zero flag.
// ----------------------------------------------------------------------------
interface dtq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               zero_input;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, zero_input,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, zero_input,
                  output ready);
endinterface

/* design/dtq_cordic_cell.sv */
// ----------------------------------------------------------------------------
// dtq_cordic_cell: one CORDIC micro-rotation
// Registered shift-add step, vectoring (steer by b) or rotation (steer by
// angle), with its sideband carried along.
// ----------------------------------------------------------------------------
module dtq_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          rot_mode_i,
  input  logic [4:0]                    shift_i,
  input  logic signed [dtq_pkg::AW-1:0] arc_i,
  input  logic                          valid_i,
  input  dtq_pkg::cord_t                cord_i,
  input  dtq_pkg::side_t                side_i,
  output logic                          valid_o,
  output dtq_pkg::cord_t                cord_o,
  output dtq_pkg::side_t                side_o
);

  logic                          valid_q;
  dtq_pkg::cord_t                cord_d, cord_q;
  dtq_pkg::side_t                side_q;
  logic signed [dtq_pkg::W-1:0]  da, db;
  logic                          pos, up;

  // direction of this step
  always_comb begin
    pos = rot_mode_i ? !cord_i.ang[dtq_pkg::AW-1] : !cord_i.b[dtq_pkg::W-1];
    up  = pos ^ rot_mode_i;
    da  = cord_i.b >>> shift_i;
    db  = cord_i.a >>> shift_i;
    if (up) begin
      cord_d.a   = cord_i.a + da;
      cord_d.b   = cord_i.b - db;
      cord_d.ang = cord_i.ang + arc_i;
    end else begin
      cord_d.a   = cord_i.a - da;
      cord_d.b   = cord_i.b + db;
      cord_d.ang = cord_i.ang - arc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign cord_o  = cord_q;
  assign side_o  = side_q;

endmodule

/* design/dtq_cordic_chain.sv */
// ----------------------------------------------------------------------------
// dtq_cordic_chain: row of CORDIC cells
// One cell per micro-rotation; each hands its vector to the next every cycle that en_i is high.
// ----------------------------------------------------------------------------
module dtq_cordic_chain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           rot_mode_i,
  input  logic           valid_i,
  input  dtq_pkg::cord_t cord_i,
  input  dtq_pkg::side_t side_i,
  output logic           valid_o,
  output dtq_pkg::cord_t cord_o,
  output dtq_pkg::side_t side_o
);

  localparam int N = dtq_pkg::CORDIC_STAGES;

  logic           valid_w [N+1];
  dtq_pkg::cord_t cord_w  [N+1];
  dtq_pkg::side_t side_w  [N+1];

  assign valid_w[0] = valid_i;
  assign cord_w[0]  = cord_i;
  assign side_w[0]  = side_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dtq_cordic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en_i),
      .rot_mode_i (rot_mode_i),
      .shift_i    (5'(i % 32)),
      .arc_i      (dtq_pkg::ARC_TABLE[i % 32]),
      .valid_i    (valid_w[i]),
      .cord_i     (cord_w[i]),
      .side_i     (side_w[i]),
      .valid_o    (valid_w[i+1]),
      .cord_o     (cord_w[i+1]),
      .side_o     (side_w[i+1])
    );
  end

  assign valid_o = valid_w[N];
  assign cord_o  = cord_w[N];
  assign side_o  = side_w[N];

endmodule

/* design/dtq_front.sv */
// ----------------------------------------------------------------------------
// dtq_front: classify and normalize
// Three stages: capture, squares and magnitude, then the zero and nearly
// parallel tests and the shift that puts the leading bit of the largest magnitude at 2^28.
// ----------------------------------------------------------------------------
module dtq_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [15:0]            dir_x_i,
  input  logic signed [15:0]            dir_y_i,
  input  logic signed [15:0]            dir_z_i,
  output logic                          valid_o,
  output logic signed [dtq_pkg::NW-1:0] xs_o,
  output logic signed [dtq_pkg::NW-1:0] ys_o,
  output logic signed [dtq_pkg::NW-1:0] zs_o,
  output dtq_pkg::cls_e                 cls_o
);

  localparam int NW = dtq_pkg::NW;

  // stage 0: capture
  logic               v0_q, v1_q, v2_q;
  logic signed [15:0] x0_q, y0_q, z0_q;
  // stage 1: squares, magnitude
  logic signed [15:0] x1_q, y1_q, z1_q;
  logic [30:0]        x2_q, y2_q, z2_q;
  logic [15:0]        m1_q;
  logic               zero1_q;
  logic signed [31:0] sqx, sqy, sqz;
  logic [15:0]        ax, ay, az, m_d;
  // stage 2
  logic [31:0]        s2;
  logic [32:0]        l2;
  logic [32:0]        scaled;
  logic               par;
  logic [4:0]         msb;
  logic [4:0]         sh;
  dtq_pkg::cls_e      cls_d, cls_q;
  logic signed [NW-1:0] xs_q, ys_q, zs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // squares and largest magnitude
  always_comb begin
    sqx = x0_q * x0_q;
    sqy = y0_q * y0_q;
    sqz = z0_q * z0_q;
    ax  = x0_q[15] ? 16'(-x0_q) : 16'(x0_q);
    ay  = y0_q[15] ? 16'(-y0_q) : 16'(y0_q);
    az  = z0_q[15] ? 16'(-z0_q) : 16'(z0_q);
    m_d = ax;
    if (ay > m_d) m_d = ay;
    if (az > m_d) m_d = az;
  end

  // parallel test s2 * 1e8 < l2, only possible for small s2
  always_comb begin
    s2     = 32'(x2_q) + 32'(y2_q);
    l2     = 33'(s2) + 33'(z2_q);
    scaled = 33'(s2[5:0]) * 33'd100000000;
    par    = (s2 < 32'd43) && (scaled < l2);
    msb    = '0;
    for (int i = 0; i < 16; i++) begin
      if (m1_q[i]) msb = 5'(i);
    end
    sh = 5'd28 - msb;
    if (zero1_q) begin
      cls_d = dtq_pkg::CLS_ZERO;
    end else if (par) begin
      cls_d = z1_q[15] ? dtq_pkg::CLS_SAME : dtq_pkg::CLS_OPP;
    end else begin
      cls_d = dtq_pkg::CLS_NORMAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= dir_x_i;
      y0_q    <= dir_y_i;
      z0_q    <= dir_z_i;
      x1_q    <= x0_q;
      y1_q    <= y0_q;
      z1_q    <= z0_q;
      x2_q    <= sqx[30:0];
      y2_q    <= sqy[30:0];
      z2_q    <= sqz[30:0];
      m1_q    <= m_d;
      zero1_q <= (x0_q == '0) && (y0_q == '0) && (z0_q == '0);
      xs_q    <= NW'(x1_q) <<< sh;
      ys_q    <= NW'(y1_q) <<< sh;
      zs_q    <= NW'(z1_q) <<< sh;
      cls_q   <= cls_d;
    end
  end

  assign valid_o = v2_q;
  assign xs_o    = xs_q;
  assign ys_o    = ys_q;
  assign zs_o    = zs_q;
  assign cls_o   = cls_q;

endmodule

/* design/direction_to_quaternion_top.sv */
// ----------------------------------------------------------------------------
// direction_to_quaternion_top: shortest-arc quaternion from a direction
// Turns the forward axis (0,0,-1) onto the given direction using a
// normalizer and four rows of CORDIC cells; result in Q1.14.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                  | Handshake
//  in_i    | in  | dir_x, dir_y, dir_z (s16)                | valid/ready
//  out_o   | out | quat_w/x/y/z (s16, Q1.14), zero_input    | valid/ready
//
//  One request per cycle while out_o does not stall; a request passes the
//  normalizer, the two vectoring rows and the rotation rows.
//  The whole pipeline advances when the output register is empty or taken;
//  a stall on out_o freezes every stage and drops in_i.ready.
//  Reset clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module direction_to_quaternion_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  dtq_in_if.sink    in_i,
  dtq_out_if.source out_o
);

  localparam int W  = dtq_pkg::W;
  localparam int AW = dtq_pkg::AW;
  localparam int NW = dtq_pkg::NW;

  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // normalizer and classifier
  logic               f_valid;
  logic signed [NW-1:0] xs, ys, zs;
  dtq_pkg::cls_e      f_cls;

  dtq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .dir_x_i (in_i.dir_x),
    .dir_y_i (in_i.dir_y),
    .dir_z_i (in_i.dir_z),
    .valid_o (f_valid),
    .xs_o    (xs),
    .ys_o    (ys),
    .zs_o    (zs),
    .cls_o   (f_cls)
  );

  // azimuth of the axis (y,-x)
  dtq_pkg::cord_t v1_in, v1_out;
  dtq_pkg::side_t v1_side_in, v1_side_out;
  logic           v1_valid;

  assign v1_in          = dtq_pkg::vec_pre(W'(ys), -W'(xs));
  assign v1_side_in.cls = f_cls;
  assign v1_side_in.aux = AW'(zs);

  dtq_cordic_chain u_vec1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .rot_mode_i (1'b0),
    .valid_i    (f_valid),
    .cord_i     (v1_in),
    .side_i     (v1_side_in),
    .valid_o    (v1_valid),
    .cord_o     (v1_out),
    .side_o     (v1_side_out)
  );

  // scale -z by the gain to match the gained horizontal length
  logic signed [NW:0]   negz;
  logic signed [62:0]   zprod;
  logic                 m_valid_q;
  logic signed [W-1:0]  m_a_q, m_b_q;
  logic signed [AW-1:0] m_phi_q;
  dtq_pkg::cls_e        m_cls_q;

  assign negz  = -((NW+1)'($signed(v1_side_out.aux[NW-1:0])));
  assign zprod = negz * dtq_pkg::K_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= v1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_a_q   <= W'(zprod >>> 30);
      m_b_q   <= v1_out.a;
      m_phi_q <= v1_out.ang;
      m_cls_q <= v1_side_out.cls;
    end
  end

  // tilt angle theta
  dtq_pkg::cord_t v2_in, v2_out;
  dtq_pkg::side_t v2_side_in, v2_side_out;
  logic           v2_valid;

  assign v2_in          = dtq_pkg::vec_pre(m_a_q, m_b_q);
  assign v2_side_in.cls = m_cls_q;
  assign v2_side_in.aux = m_phi_q;

  dtq_cordic_chain u_vec2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .rot_mode_i (1'b0),
    .valid_i    (m_valid_q),
    .cord_i     (v2_in),
    .side_i     (v2_side_in),
    .valid_o    (v2_valid),
    .cord_o     (v2_out),
    .side_o     (v2_side_out)
  );

  // cos/sin of theta/2 and of phi, side by side
  dtq_pkg::cord_t rh_in, rh_out, rp_in, rp_out;
  dtq_pkg::side_t rh_side_in, rh_side_out, rp_side_out;
  logic           rh_valid, rp_valid;

  assign rh_in          = dtq_pkg::rot_pre(v2_out.ang >>> 1);
  assign rp_in          = dtq_pkg::rot_pre(v2_side_out.aux);
  assign rh_side_in.cls = v2_side_out.cls;
  assign rh_side_in.aux = '0;

  dtq_cordic_chain u_rot_half (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .rot_mode_i (1'b1),
    .valid_i    (v2_valid),
    .cord_i     (rh_in),
    .side_i     (rh_side_in),
    .valid_o    (rh_valid),
    .cord_o     (rh_out),
    .side_o     (rh_side_out)
  );

  dtq_cordic_chain u_rot_phi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .rot_mode_i (1'b1),
    .valid_i    (v2_valid),
    .cord_i     (rp_in),
    .side_i     (rh_side_in),
    .valid_o    (rp_valid),
    .cord_o     (rp_out),
    .side_o     (rp_side_out)
  );

  // axis components: sin(h) * cos(phi), sin(h) * sin(phi)
  logic signed [31:0] s32, cp32, sp32;
  logic signed [63:0] px, py;
  logic               p_valid_q;
  logic signed [31:0] p_w_q, p_x_q, p_y_q;
  dtq_pkg::cls_e      p_cls_q;

  assign s32  = 32'(rh_out.b);
  assign cp32 = 32'(rp_out.a);
  assign sp32 = 32'(rp_out.b);
  assign px   = s32 * cp32;
  assign py   = s32 * sp32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q <= rh_valid && rp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_w_q   <= 32'(rh_out.a);
      p_x_q   <= px[61:30];
      p_y_q   <= py[61:30];
      p_cls_q <= (rp_side_out.cls == rh_side_out.cls) ? rh_side_out.cls
                                                      : rp_side_out.cls;
    end
  end

  // output register: format conversion and special cases
  logic [15:0] w_d, x_d, y_d;
  logic        zf_d;
  logic [15:0] w_q, x_q, y_q;
  logic        zf_q;

  always_comb begin
    w_d  = dtq_pkg::to_out(40'(p_w_q));
    x_d  = dtq_pkg::to_out(40'(p_x_q));
    y_d  = dtq_pkg::to_out(40'(p_y_q));
    zf_d = 1'b0;
    unique case (p_cls_q)
      dtq_pkg::CLS_ZERO: begin
        w_d  = dtq_pkg::OUT_ONE;
        x_d  = '0;
        y_d  = '0;
        zf_d = 1'b1;
      end
      dtq_pkg::CLS_SAME: begin
        w_d = dtq_pkg::OUT_ONE;
        x_d = '0;
        y_d = '0;
      end
      dtq_pkg::CLS_OPP: begin
        w_d = '0;
        x_d = '0;
        y_d = dtq_pkg::OUT_ONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q  <= w_d;
      x_q  <= x_d;
      y_q  <= y_d;
      zf_q <= zf_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.quat_w     = w_q;
  assign out_o.quat_x     = x_q;
  assign out_o.quat_y     = y_q;
  assign out_o.quat_z     = '0;
  assign out_o.zero_input = zf_q;

endmodule

/* design/dtq_checker.sv */
// ----------------------------------------------------------------------------
// dtq_checker: port-level checks
// Watches the result channel and the request ready of the top level; bound in below.
// ----------------------------------------------------------------------------
module dtq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] quat_w_i,
  input logic [15:0] quat_x_i,
  input logic [15:0] quat_y_i,
  input logic [15:0] quat_z_i,
  input logic        zero_input_i
);

  // a zero vector always reports the identity
  a_zero_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_input_i |->
      quat_w_i == dtq_pkg::OUT_ONE && quat_x_i == '0 && quat_y_i == '0)
    else $error("zero input without identity");

  // axis lies in the xy plane
  a_z_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> quat_z_i == '0)
    else $error("quat_z not zero");

  // a stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken during stall");

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(quat_w_i) &&
      $stable(quat_x_i) && $stable(quat_y_i) && $stable(zero_input_i))
    else $error("stalled result changed");

endmodule

bind direction_to_quaternion_top dtq_checker u_dtq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .quat_w_i     (out_o.quat_w),
  .quat_x_i     (out_o.quat_x),
  .quat_y_i     (out_o.quat_y),
  .quat_z_i     (out_o.quat_z),
  .zero_input_i (out_o.zero_input)
);
